[sv/spp_pkg.sv]
package spp_pkg;

    // sizes and constants
    localparam int NODES_DEF   = 32;
    localparam int MAX_RESULTS = 32;
    localparam int FIELD_W     = 5;
    localparam int WEIGHT_W    = 4;
    localparam int DIST_W      = 8;

    localparam logic [DIST_W-1:0]   UNREACHABLE = 8'd255;
    localparam logic [WEIGHT_W-1:0] MAX_WEIGHT  = 4'd9;

    // request kinds
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_PLAN = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [FIELD_W-1:0] edge_from;
        logic [FIELD_W-1:0] edge_to;
        logic [WEIGHT_W-1:0] edge_weight;
        logic [FIELD_W-1:0] start_node;
        logic [FIELD_W-1:0] goal_node;
    } req_t;

    typedef struct packed {
        logic [FIELD_W-1:0] path_node;
        logic               last;
        logic               no_path;
    } res_t;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic load;
        logic plan;
        logic pass;
        logic relax;
        logic walk_start;
        logic emit_path;
        logic emit_fail;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic bad_node;
        logic found;
        logic iter_done;
        logic pass_done;
        logic unreach;
        logic walk_last;
        logic out_free;
    } sts_t;

endpackage

[sv/spp_ram.sv]
module spp_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

[sv/spp_ctrl.sv]
module spp_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_type,
    output logic          req_ready,
    input  spp_pkg::sts_t sts,
    output spp_pkg::cmd_t cmd
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_PREP  = 7'b0000100,
        S_RELAX = 7'b0001000,
        S_CHECK = 7'b0010000,
        S_FAIL  = 7'b0100000,
        S_WALK  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (req_type == spp_pkg::REQ_PLAN)
                    begin
                        cmd.plan   = 1'b1;
                        state_next = S_PREP;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            S_PREP:
            begin
                if (sts.bad_node)
                begin
                    state_next = S_FAIL;
                end
                else if (sts.found && !sts.iter_done)
                begin
                    cmd.pass   = 1'b1;
                    state_next = S_RELAX;
                end
                else
                begin
                    cmd.walk_start = 1'b1;
                    state_next     = S_CHECK;
                end
            end
            S_RELAX:
            begin
                cmd.relax = 1'b1;
                if (sts.pass_done)
                begin
                    state_next = S_PREP;
                end
            end
            S_CHECK:
            begin
                if (sts.unreach)
                begin
                    state_next = S_FAIL;
                end
                else
                begin
                    state_next = S_WALK;
                end
            end
            S_FAIL:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_fail = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_WALK:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_path = 1'b1;
                    if (sts.walk_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/spp_dp.sv]
module spp_dp #(
    parameter int NODES = spp_pkg::NODES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  spp_pkg::req_t req,
    input  spp_pkg::cmd_t cmd,
    output spp_pkg::sts_t sts,
    output spp_pkg::res_t res,
    output logic          res_valid,
    input  logic          res_ready
);

    localparam int NW = $clog2(NODES);
    localparam int CW = $clog2(NODES + 1);
    localparam int AW = $clog2(NODES * NODES);
    localparam int KW = $clog2(spp_pkg::MAX_RESULTS + 1);
    localparam int DW = spp_pkg::DIST_W;
    localparam int WW = spp_pkg::WEIGHT_W;

    logic [AW-1:0]              clr_reg;
    logic [spp_pkg::FIELD_W-1:0] start_reg;
    logic [spp_pkg::FIELD_W-1:0] goal_reg;
    logic [NW-1:0]              u_reg;
    logic [DW-1:0]              du_reg;
    logic [DW-1:0]              minv_reg;
    logic [NW-1:0]              best_reg;
    logic                       found_reg;
    logic [CW-1:0]              acnt_reg;
    logic [NW-1:0]              idx_reg;
    logic                       rdv_reg;
    logic [CW-1:0]              iter_reg;
    logic [KW-1:0]              k_reg;
    logic [DW-1:0]              dist_reg [NODES];
    logic                       vis_reg  [NODES];
    logic [NW-1:0]              pred_reg [NODES];
    spp_pkg::res_t              out_reg;
    logic                       out_valid_reg;

    logic                       load_ok;
    logic [WW-1:0]              load_w;
    logic [AW-1:0]              load_addr;
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [WW-1:0]              ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [WW-1:0]              ram_rdata;
    logic                       issue;
    logic [NW-1:0]              goal_idx;
    logic [NW-1:0]              start_idx;
    logic [DW:0]                sum;
    logic                       upd;
    logic [DW-1:0]              newd;
    logic                       cand;
    logic                       out_free;

    assign goal_idx  = NW'(goal_reg);
    assign start_idx = NW'(start_reg);

    // edge write address and saturated weight
    assign load_ok   = (int'(req.edge_from) < NODES) && (int'(req.edge_to) < NODES);
    assign load_w    = (req.edge_weight > spp_pkg::MAX_WEIGHT) ? spp_pkg::MAX_WEIGHT
                                                               : req.edge_weight;
    assign load_addr = AW'(NW'(req.edge_from)) * AW'(NODES) + AW'(NW'(req.edge_to));

    // weight store port selection
    assign ram_we    = cmd.clear || (cmd.load && load_ok);
    assign ram_waddr = cmd.clear ? clr_reg : load_addr;
    assign ram_wdata = cmd.clear ? '0 : load_w;
    assign issue     = cmd.relax && (acnt_reg < CW'(NODES));
    assign ram_raddr = AW'(u_reg) * AW'(NODES) + AW'(acnt_reg[NW-1:0]);

    spp_ram #(
        .WIDTH(WW),
        .DEPTH(NODES * NODES)
    ) u_weights (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // relaxation of one neighbor and running minimum for the next pass
    assign sum  = {1'b0, du_reg} + (DW + 1)'(ram_rdata);
    assign upd  = !vis_reg[idx_reg] && (ram_rdata != '0) && (sum < {1'b0, dist_reg[idx_reg]});
    assign newd = upd ? sum[DW-1:0] : dist_reg[idx_reg];
    assign cand = !vis_reg[idx_reg] && (newd < minv_reg);

    assign out_free = !out_valid_reg || res_ready;

    // status back to the controller
    always_comb
    begin
        sts.clear_done = (clr_reg == AW'(NODES * NODES - 1));
        sts.bad_node   = (int'(start_reg) >= NODES) || (int'(goal_reg) >= NODES);
        sts.found      = found_reg;
        sts.iter_done  = (iter_reg == CW'(NODES - 1));
        sts.pass_done  = rdv_reg && (idx_reg == NW'(NODES - 1));
        sts.unreach    = (dist_reg[idx_reg] == spp_pkg::UNREACHABLE);
        sts.walk_last  = (idx_reg == goal_idx)
                      || (k_reg == KW'(spp_pkg::MAX_RESULTS - 1))
                      || (int'(k_reg) == NODES - 1);
        sts.out_free   = out_free;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            found_reg     <= 1'b0;
            acnt_reg      <= '0;
            rdv_reg       <= 1'b0;
            iter_reg      <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.plan)
            begin
                found_reg <= 1'b1;
                iter_reg  <= '0;
            end
            if (cmd.pass)
            begin
                found_reg <= 1'b0;
                iter_reg  <= iter_reg + CW'(1);
                acnt_reg  <= '0;
            end
            else if (issue)
            begin
                acnt_reg <= acnt_reg + CW'(1);
            end
            if (rdv_reg && cand)
            begin
                found_reg <= 1'b1;
            end
            rdv_reg <= issue;
            if (cmd.walk_start)
            begin
                k_reg <= '0;
            end
            else if (cmd.emit_path)
            begin
                k_reg <= k_reg + KW'(1);
            end
            if (cmd.emit_path || cmd.emit_fail)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // search arrays, node registers and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.plan)
        begin
            start_reg <= req.start_node;
            goal_reg  <= req.goal_node;
            for (int i = 0; i < NODES; i++)
            begin
                dist_reg[i] <= (NW'(i) == NW'(req.goal_node)) ? '0 : spp_pkg::UNREACHABLE;
                vis_reg[i]  <= 1'b0;
            end
            best_reg <= NW'(req.goal_node);
            minv_reg <= '0;
        end
        if (cmd.pass)
        begin
            u_reg             <= best_reg;
            du_reg            <= minv_reg;
            vis_reg[best_reg] <= 1'b1;
            minv_reg          <= spp_pkg::UNREACHABLE;
        end
        if (rdv_reg)
        begin
            if (upd)
            begin
                dist_reg[idx_reg] <= sum[DW-1:0];
                pred_reg[idx_reg] <= u_reg;
            end
            if (cand)
            begin
                minv_reg <= newd;
                best_reg <= idx_reg;
            end
        end
        if (cmd.walk_start)
        begin
            idx_reg <= start_idx;
        end
        else if (cmd.relax)
        begin
            idx_reg <= acnt_reg[NW-1:0];
        end
        else if (cmd.emit_path)
        begin
            idx_reg <= pred_reg[idx_reg];
        end
        if (cmd.emit_fail)
        begin
            out_reg.path_node <= start_reg;
            out_reg.last      <= 1'b1;
            out_reg.no_path   <= 1'b1;
        end
        else if (cmd.emit_path)
        begin
            out_reg.path_node <= spp_pkg::FIELD_W'(idx_reg);
            out_reg.last      <= sts.walk_last;
            out_reg.no_path   <= 1'b0;
        end
    end

    assign res       = out_reg;
    assign res_valid = out_valid_reg;

    // a result is only written into a free output slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_path || cmd.emit_fail) |-> (!out_valid_reg || res_ready))
        else $error("result written over an unaccepted result");

    // the chosen node is marked done once its pass begins
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pass |=> vis_reg[u_reg])
        else $error("selected node not marked visited");

    // a failure result always closes the plan
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.no_path) |-> out_reg.last)
        else $error("failure result without last");

endmodule

[sv/shortest_path_planner.sv]
// channel   dir  handshake            payload
// req       in   req_valid/req_ready  spp_pkg::req_t  (edge load or plan)
// res       out  res_valid/res_ready  spp_pkg::res_t  (one path node)
//
// after reset the weight store is swept to zero, one entry per cycle,
// all NODES*NODES entries (1024 at 32 nodes), with req_ready low
// an edge load is written to the weight store as it is accepted, and req_ready stays high
// a plan searches pass by pass, each pass reading one row of weights through the single
// read port of the weight store (one weight per cycle), then emits one result per path node
// results wait in an output register; res_ready low only holds the path walk and the failure result
module shortest_path_planner #(
    parameter int NODES = spp_pkg::NODES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  spp_pkg::req_t req,
    output logic          res_valid,
    input  logic          res_ready,
    output spp_pkg::res_t res
);

    spp_pkg::cmd_t cmd;
    spp_pkg::sts_t sts;

    // sequencing
    spp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_type (req.req_type),
        .req_ready(req_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // weight store, search arrays and result register
    spp_dp #(
        .NODES(NODES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cmd      (cmd),
        .sts      (sts),
        .res      (res),
        .res_valid(res_valid),
        .res_ready(res_ready)
    );

endmodule

[dv/tb_shortest_path_planner.sv]
`timescale 1ns / 100ps

module tb_shortest_path_planner;

    localparam int N        = spp_pkg::NODES_DEF;
    localparam int IDLE_MAX = 20000;

    // path checker: keeps the pending path nodes and compares results
    class path_scoreboard;
        spp_pkg::res_t pending_q[$];
        int   errors;
        int   n_checked;
        int   n_plans;
        int   n_loads;

        function void note_request(spp_pkg::res_t expected[$]);
            foreach (expected[i]) pending_q.push_back(expected[i]);
        endfunction

        function void check_result(spp_pkg::res_t actual);
            spp_pkg::res_t exp_res;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %p", $time, actual);
                errors++;
                return;
            end
            exp_res = pending_q.pop_front();
            n_checked++;
            if (exp_res.path_node !== actual.path_node)
            begin
                $display("%0t: path_node mismatch, expected %0d, actual %0d",
                         $time, exp_res.path_node, actual.path_node);
                errors++;
            end
            if (exp_res.last !== actual.last)
            begin
                $display("%0t: last mismatch, expected %0b, actual %0b",
                         $time, exp_res.last, actual.last);
                errors++;
            end
            if (exp_res.no_path !== actual.no_path)
            begin
                $display("%0t: no_path mismatch, expected %0b, actual %0b",
                         $time, exp_res.no_path, actual.no_path);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    spp_pkg::req_t req;
    logic res_valid;
    logic res_ready;
    spp_pkg::res_t res;

    path_scoreboard sb;

    // graph copy for prediction
    logic [spp_pkg::WEIGHT_W-1:0] graph_w [N][N];

    int  idle_cycles;
    bit  random_sink;

    shortest_path_planner DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // compute expected path for one request, or apply a load to the graph copy
    function automatic void predict_path(spp_pkg::req_t r, ref spp_pkg::res_t out_q[$]);
        logic [spp_pkg::DIST_W-1:0]   dist_arr [N];
        bit                           seen [N];
        logic [spp_pkg::FIELD_W-1:0]  pred [N];
        int                           best;
        int                           minv;
        int                           sum;
        int                           node;
        logic [spp_pkg::WEIGHT_W-1:0] w;
        spp_pkg::res_t                item;
        out_q.delete();
        if (r.req_type == spp_pkg::REQ_LOAD)
        begin
            w = (r.edge_weight > spp_pkg::MAX_WEIGHT) ? spp_pkg::MAX_WEIGHT : r.edge_weight;
            if (r.edge_from < N && r.edge_to < N) graph_w[r.edge_from][r.edge_to] = w;
            return;
        end
        if (r.start_node >= N || r.goal_node >= N)
        begin
            item = '{path_node: r.start_node, last: 1'b1, no_path: 1'b1};
            out_q.push_back(item);
            return;
        end
        for (int i = 0; i < N; i++)
        begin
            dist_arr[i] = spp_pkg::UNREACHABLE;
            seen[i] = 0;
            pred[i] = '0;
        end
        dist_arr[r.goal_node] = '0;
        for (int it = 0; it + 1 < N; it++)
        begin
            minv = spp_pkg::UNREACHABLE;
            best = -1;
            for (int i = 0; i < N; i++)
                if (!seen[i] && dist_arr[i] < minv)
                begin
                    minv = dist_arr[i];
                    best = i;
                end
            if (best < 0) break;
            seen[best] = 1;
            for (int l = 0; l < N; l++)
            begin
                sum = dist_arr[best] + graph_w[best][l];
                if (!seen[l] && graph_w[best][l] != 0 && sum < dist_arr[l])
                begin
                    pred[l] = best[spp_pkg::FIELD_W-1:0];
                    dist_arr[l] = sum[spp_pkg::DIST_W-1:0];
                end
            end
        end
        if (dist_arr[r.start_node] == spp_pkg::UNREACHABLE)
        begin
            item = '{path_node: r.start_node, last: 1'b1, no_path: 1'b1};
            out_q.push_back(item);
            return;
        end
        node = r.start_node;
        for (int k = 0; k < spp_pkg::MAX_RESULTS && k < N; k++)
        begin
            if (node == r.goal_node || k + 1 == spp_pkg::MAX_RESULTS || k + 1 == N)
            begin
                item = '{path_node: node[spp_pkg::FIELD_W-1:0], last: 1'b1, no_path: 1'b0};
                out_q.push_back(item);
                return;
            end
            item = '{path_node: node[spp_pkg::FIELD_W-1:0], last: 1'b0, no_path: 1'b0};
            out_q.push_back(item);
            node = pred[node] % N;
        end
    endfunction

    // send one request, predicting on acceptance
    task automatic send_request(spp_pkg::req_t r);
        spp_pkg::res_t exp_q[$];
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        predict_path(r, exp_q);
        sb.note_request(exp_q);
        if (r.req_type == spp_pkg::REQ_PLAN) sb.n_plans++;
        else sb.n_loads++;
    endtask

    // close a burst with an idle gap
    task automatic idle_gap(int cycles);
        req_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    function automatic spp_pkg::req_t load_req(int f, int t, int w);
        spp_pkg::req_t r;
        r = '0;
        r.req_type    = spp_pkg::REQ_LOAD;
        r.edge_from   = f[spp_pkg::FIELD_W-1:0];
        r.edge_to     = t[spp_pkg::FIELD_W-1:0];
        r.edge_weight = w[spp_pkg::WEIGHT_W-1:0];
        r.start_node  = spp_pkg::FIELD_W'($urandom);
        r.goal_node   = spp_pkg::FIELD_W'($urandom);
        return r;
    endfunction

    function automatic spp_pkg::req_t plan_req(int s, int g);
        spp_pkg::req_t r;
        r = spp_pkg::req_t'($bits(spp_pkg::req_t)'($urandom));
        r.req_type   = spp_pkg::REQ_PLAN;
        r.start_node = s[spp_pkg::FIELD_W-1:0];
        r.goal_node  = g[spp_pkg::FIELD_W-1:0];
        return r;
    endfunction

    // receiver stall pattern: alternate full-speed and random stretches
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ready <= 1'b0;
        else if (!random_sink)
            res_ready <= 1'b1;
        else
            res_ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        if (rst_n && ($urandom_range(0, 63) == 0)) random_sink <= ~random_sink;
    end

    // result monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && res_ready) sb.check_result(res);
            if ((res_valid && res_ready) || (req_valid && req_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_MAX)
            begin
                $display("watchdog expired with %0d results pending", sb.pending_q.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        int burst;
        int kind;
        int a;
        int b;
        sb          = new();
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        idle_cycles = 0;
        random_sink = 0;
        for (int i = 0; i < N; i++)
            for (int j = 0; j < N; j++)
                graph_w[i][j] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty graph, start equals goal, chain, weights, overwrite, removal
        send_request(plan_req(3, 7));
        send_request(plan_req(5, 5));
        send_request(load_req(0, 1, 1));
        send_request(load_req(1, 2, 9));
        send_request(load_req(2, 31, 15));
        send_request(load_req(0, 31, 12));
        send_request(plan_req(31, 0));
        send_request(plan_req(0, 31));
        idle_gap(3);
        send_request(load_req(0, 31, 0));
        send_request(plan_req(0, 31));
        send_request(load_req(31, 0, 4));
        send_request(load_req(31, 0, 10));
        send_request(plan_req(31, 2));
        send_request(plan_req(31, 31));
        send_request(plan_req(0, 0));
        // long chain covering every node, ties between equal routes
        for (int i = 0; i < N - 1; i++)
            send_request(load_req(i + 1, i, 1));
        send_request(load_req(5, 3, 2));
        send_request(plan_req(31, 0));
        send_request(plan_req(17, 3));
        idle_gap(2);

        // random: mostly loads with random content, plans interleaved
        for (int n = 0; n < 180; )
        begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst; k++)
            begin
                kind = $urandom_range(0, 9);
                a = $urandom_range(0, 31);
                b = $urandom_range(0, 31);
                if (kind < 7)
                    send_request(load_req(a, b, (kind == 0) ? 0 : $urandom_range(0, 15)));
                else if (kind < 9)
                    send_request(plan_req(a, b));
                else
                    send_request(plan_req(a, $urandom_range(0, 1) ? a : (a + 1) % N));
                n++;
            end
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 8));
        end
        req_valid <= 1'b0;

        // drain remaining path nodes
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (1200) @(posedge clk);

        $display("covered %0d edge loads and %0d plans, %0d path nodes checked",
                 sb.n_loads, sb.n_plans, sb.n_checked);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
